@@ rtl/mbrq_pkg.sv @@
// Shared types and constants for the multi-byte ring queue.
// No dependencies; the modules under rtl/ import it.
`default_nettype none

package mbrq_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned NUM_QUEUES = 3;
  localparam int unsigned SEL_W      = 2;
  localparam int unsigned FLAGS_W    = NUM_QUEUES;

  // Request codes carried on req_type_i
  typedef enum logic [1:0] {
    REQ_ENQ       = 2'd0,
    REQ_DEQ       = 2'd1,
    REQ_CLR_PTR   = 2'd2,
    REQ_CLR_FLAGS = 2'd3
  } req_e;

  // Queue numbers carried on queue_sel_i
  localparam logic [SEL_W-1:0] Q_WL_SEND   = 2'd0;
  localparam logic [SEL_W-1:0] Q_UART_SEND = 2'd1;
  localparam logic [SEL_W-1:0] Q_UART_RECV = 2'd2;

  // Per-queue command from the top level
  typedef struct packed {
    logic              enq;
    logic              deq;
    logic              clr;
    logic              stab;
    logic [BYTE_W-1:0] data;
  } q_cmd_t;

  // Per-queue status back to the top level
  typedef struct packed {
    logic ok;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

@@ rtl/mbrq_mem.sv @@
// Byte store with one write port and one registered read port.
// Depends on mbrq_pkg for the byte width.
`default_nettype none

module mbrq_mem
  import mbrq_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [BYTE_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/mbrq_queue.sv @@
// One ring queue: head and tail pointers around a byte store.
// Depends on mbrq_pkg and mbrq_mem.
`default_nettype none

module mbrq_queue
  import mbrq_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire q_cmd_t            cmd_i,
  output q_stat_t                stat_o,
  output logic      [BYTE_W-1:0] rdata_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [AW-1:0] head_nxt, tail_nxt;
  logic          full, empty, wr_en, rd_en;

  // Wrap at DEPTH-1, so any depth works, not only powers of two
  assign head_nxt = (head_q == LAST) ? '0 : head_q + 1'b1;
  assign tail_nxt = (tail_q == LAST) ? '0 : tail_q + 1'b1;
  assign full     = (head_q == tail_nxt);
  assign empty    = (head_q == tail_q);

  // Before stabilization an enqueue answers ok but drops the byte
  assign wr_en = cmd_i.enq & ~full & cmd_i.stab;
  assign rd_en = cmd_i.deq & ~empty;

  assign stat_o.ok   = (cmd_i.enq & ~full) | rd_en;
  assign stat_o.full = full;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    priority if (cmd_i.clr) begin
      head_d = '0;
      tail_d = '0;
    end else if (wr_en) begin
      tail_d = tail_nxt;
    end else if (rd_en) begin
      head_d = head_nxt;
    end else begin
      // hold both pointers
      head_d = head_q;
      tail_d = tail_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  mbrq_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (tail_q),
    .wdata_i (cmd_i.data),
    .re_i    (rd_en),
    .raddr_i (head_q),
    .rdata_o (rdata_o)
  );

endmodule

`default_nettype wire

@@ rtl/multi_byte_ring_queue.sv @@
// Top level of the multi-byte ring queue: three byte queues and the sticky flags.
// Depends on mbrq_pkg, mbrq_queue and mbrq_mem.
//
//  channel   | handshake       | word fields
//  ----------+-----------------+-----------------------------------------------
//  request   | start_i, busy_o | req_type_i, queue_sel_i, data_byte_i,
//            |                 | stabilized_i
//  response  | done_o (strobe) | ok_o, read_byte_o, overflow_flags_o
//
// A request word is taken at any edge with start_i high and busy_o low; busy_o
// stays low, so a word may enter every cycle. Its response shows in the next
// cycle, for one cycle, with done_o high; the registered read port of the
// byte stores delivers a dequeued byte alongside it. Pointers and flags update
// at the accept edge, so a following word sees them at once. Reset clears the
// pointers, the flags and the strobe; the byte stores keep whatever they held.
// The receiver cannot stall, so nothing is held back on the response side.
`default_nettype none

module multi_byte_ring_queue
  import mbrq_pkg::*;
#(
  parameter int unsigned WL_SEND_DEPTH   = 256,
  parameter int unsigned UART_SEND_DEPTH = 256,
  parameter int unsigned UART_RECV_DEPTH = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [1:0]         req_type_i,
  input  wire logic [SEL_W-1:0]   queue_sel_i,
  input  wire logic [BYTE_W-1:0]  data_byte_i,
  input  wire logic               stabilized_i,
  output logic                    done_o,
  output logic                    ok_o,
  output logic      [BYTE_W-1:0]  read_byte_o,
  output logic      [FLAGS_W-1:0] overflow_flags_o
);

  req_e              req;
  logic              accept;
  q_cmd_t            cmd  [NUM_QUEUES];
  q_stat_t           stat [NUM_QUEUES];
  logic [BYTE_W-1:0] rdata [NUM_QUEUES];

  logic [FLAGS_W-1:0] flags_q, flags_d;
  logic               done_q, done_d;
  logic               ok_q, ok_d;
  logic               rd_hit_q, rd_hit_d;
  logic [SEL_W-1:0]   rd_sel_q;

  // Take a word every cycle; the queues never need a wait
  assign busy_o = 1'b0;
  assign accept = start_i & ~busy_o;
  assign req    = req_e'(req_type_i);

  // Steer the request to the selected queue; queue number 3 reaches none
  always_comb begin
    for (int i = 0; i < NUM_QUEUES; i++) begin
      cmd[i].enq  = accept && (req == REQ_ENQ)     && (queue_sel_i == SEL_W'(i));
      cmd[i].deq  = accept && (req == REQ_DEQ)     && (queue_sel_i == SEL_W'(i));
      cmd[i].clr  = accept && (req == REQ_CLR_PTR) && (queue_sel_i == SEL_W'(i));
      cmd[i].stab = stabilized_i;
      cmd[i].data = data_byte_i;
    end
  end

  mbrq_queue #(.DEPTH(WL_SEND_DEPTH)) u_wl_send (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd[Q_WL_SEND]),
    .stat_o  (stat[Q_WL_SEND]),
    .rdata_o (rdata[Q_WL_SEND])
  );

  mbrq_queue #(.DEPTH(UART_SEND_DEPTH)) u_uart_send (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd[Q_UART_SEND]),
    .stat_o  (stat[Q_UART_SEND]),
    .rdata_o (rdata[Q_UART_SEND])
  );

  mbrq_queue #(.DEPTH(UART_RECV_DEPTH)) u_uart_recv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd[Q_UART_RECV]),
    .stat_o  (stat[Q_UART_RECV]),
    .rdata_o (rdata[Q_UART_RECV])
  );

  // Sticky flags: set on an enqueue into a full queue, drop only on a flag clear or reset
  always_comb begin
    flags_d = flags_q;
    ok_d    = 1'b0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      if (cmd[i].enq && stat[i].full) begin
        flags_d[i] = 1'b1;
      end
      ok_d = ok_d | stat[i].ok;
    end
    if (accept && (req == REQ_CLR_FLAGS)) begin
      flags_d = '0;
    end
  end

  // Only a successful dequeue puts store data on read_byte_o
  assign rd_hit_d = accept && (req == REQ_DEQ) && ok_d;
  assign done_d   = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q  <= '0;
      done_q   <= 1'b0;
      rd_hit_q <= 1'b0;
    end else begin
      flags_q  <= flags_d;
      done_q   <= done_d;
      rd_hit_q <= rd_hit_d;
    end
  end

  // Response payload: hold the selection until the store data arrives
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q     <= ok_d;
      rd_sel_q <= queue_sel_i;
    end
  end

  always_comb begin
    read_byte_o = '0;
    if (rd_hit_q) begin
      unique case (rd_sel_q)
        Q_WL_SEND:   read_byte_o = rdata[Q_WL_SEND];
        Q_UART_SEND: read_byte_o = rdata[Q_UART_SEND];
        Q_UART_RECV: read_byte_o = rdata[Q_UART_RECV];
        default:     read_byte_o = '0;
      endcase
    end
  end

  assign done_o           = done_q;
  assign ok_o             = ok_q;
  assign overflow_flags_o = flags_q;

endmodule

`default_nettype wire

@@ rtl/mbrq_checker.sv @@
// Port-level checker for the multi-byte ring queue, bound to the top level.
// Depends on mbrq_pkg and multi_byte_ring_queue.
`default_nettype none

module mbrq_checker
  import mbrq_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start_i,
  input wire logic               busy_o,
  input wire logic [1:0]         req_type_i,
  input wire logic [SEL_W-1:0]   queue_sel_i,
  input wire logic [BYTE_W-1:0]  data_byte_i,
  input wire logic               stabilized_i,
  input wire logic               done_o,
  input wire logic               ok_o,
  input wire logic [BYTE_W-1:0]  read_byte_o,
  input wire logic [FLAGS_W-1:0] overflow_flags_o
);

  // Every accepted word answers in the next cycle
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("accepted word got no response");

  // No response without a request
  a_no_stray_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("response without a request");

  // Failed answers carry a zero byte
  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ok_o) |-> (read_byte_o == '0))
    else $error("nonzero byte on a failed response");

  // Clear requests never report success
  a_clear_not_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o &&
     (req_type_i == REQ_CLR_PTR || req_type_i == REQ_CLR_FLAGS)) |=> !ok_o)
    else $error("clear request reported ok");

  // Flags only drop through a flag-clear request
  a_flags_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(rst_ni) &&
     !($past(start_i) && !$past(busy_o) && $past(req_type_i) == REQ_CLR_FLAGS))
    |-> ((overflow_flags_o & $past(overflow_flags_o)) == $past(overflow_flags_o)))
    else $error("overflow flag dropped without a clear");

endmodule

bind multi_byte_ring_queue mbrq_checker u_mbrq_checker (.*);

`default_nettype wire
